// ===== design/iva_pkg.sv =====
// ----------------------------------------------------------------------------
// iva_pkg
// Shared types and codes of the interrupt vector allocator.
// ----------------------------------------------------------------------------
package iva_pkg;

    localparam logic OP_LEVEL = 1'b0;
    localparam logic OP_FIXED = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    localparam logic [1:0] PIN_ANY = 2'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       shareable;
        logic       moveable;
        logic [1:0] polarity;
        logic [1:0] trigger;
    } t_marks;

    typedef struct packed {
        logic       want_share;
        logic       want_move;
        logic       check_move;
        logic [1:0] polarity;
        logic [1:0] trigger;
    } t_req;

endpackage

// ===== design/iva_ram.sv =====
// ----------------------------------------------------------------------------
// iva_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module iva_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/iva_select.sv =====
// ----------------------------------------------------------------------------
// iva_select
// Checks one slot per cycle against a request and keeps the best candidate.
// ----------------------------------------------------------------------------
module iva_select #(
    parameter int SLOT_W      = 8,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clear,
    input  logic                   i_valid,
    input  logic [SLOT_W-1:0]      i_idx,
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  iva_pkg::t_marks        i_marks,
    input  iva_pkg::t_req          i_req,
    output logic                   o_found,
    output logic [SLOT_W-1:0]      o_idx,
    output logic [COUNT_WIDTH-1:0] o_count
);

    logic                   r_found;
    logic [SLOT_W-1:0]      r_idx;
    logic [COUNT_WIDTH-1:0] r_count;

    logic pol_ok;
    logic trg_ok;
    logic move_ok;
    logic fits;
    logic better;

    always_comb begin
        pol_ok  = (i_marks.polarity == i_req.polarity) ||
                  (i_marks.polarity == iva_pkg::PIN_ANY) ||
                  (i_req.polarity == iva_pkg::PIN_ANY);
        trg_ok  = (i_marks.trigger == i_req.trigger) ||
                  (i_marks.trigger == iva_pkg::PIN_ANY) ||
                  (i_req.trigger == iva_pkg::PIN_ANY);
        move_ok = !i_req.check_move || (i_marks.moveable == i_req.want_move);
        fits    = (i_count == '0) ||
                  (i_marks.shareable && i_req.want_share && move_ok && pol_ok && trg_ok);
        better  = !r_found || (r_count > i_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_clear) begin
            r_found <= 1'b0;
        end else if (i_valid && fits && better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && fits && better && !i_clear) begin
            r_idx   <= i_idx;
            r_count <= i_count;
        end
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;
    assign o_count = r_count;

endmodule

// ===== design/irq_vector_allocator.sv =====
// ----------------------------------------------------------------------------
// irq_vector_allocator
// Interrupt vector slot table with allocate-by-level and allocate-fixed.
//
// A request arrives as one transaction on the s_axis channel (tuser is the
// operation, tdata the request fields) and yields exactly one result
// transaction on the m_axis channel (tuser is the status, tdata the granted
// vector and its new user count). The clock level register is written over
// the cfg channel, which is always ready.
// After reset the slot table is cleared by a pass over all NUM_SLOTS slots,
// one slot per cycle, and no request is taken until it ends.
// A request scans the slot table through one RAM read port and one shared
// compare unit, one slot per cycle. A level request scans the slots of its
// level; if none fits, a widened search scans from the level base up to the
// clock level base. A fixed request checks only its own slot.
// The next request is taken as soon as the sequencer is idle; a result that
// the receiver stalls holds in the output register, and the following
// request finishes its scan but completes only once that register is free.
// ----------------------------------------------------------------------------
module irq_vector_allocator #(
    parameter int NUM_SLOTS       = 256,
    parameter int SLOTS_PER_LEVEL = 16,
    parameter int COUNT_WIDTH     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // level[3:0], vector[11:4], want_share[12], want_move[13],
    // widen_search[14], pin_polarity[16:15], pin_trigger[18:17], zero above
    input  logic [23:0] s_axis_tdata,
    // op
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // assigned_vector[7:0], users_now[15:8]
    output logic [15:0] m_axis_tdata,
    // status
    output logic        m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int SPAN   = 16 * SLOTS_PER_LEVEL;
    localparam int TOP_A  = (SPAN > NUM_SLOTS) ? SPAN : NUM_SLOTS;
    localparam int TOP_B  = (TOP_A > 256) ? TOP_A : 256;
    localparam int VW     = $clog2(TOP_B + 1);
    localparam int MARK_W = $bits(iva_pkg::t_marks);
    localparam int DATA_W = COUNT_WIDTH + MARK_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [VW-1:0] SLOTS_V = VW'(NUM_SLOTS);
    localparam logic [VW-1:0] SPL_V   = VW'(SLOTS_PER_LEVEL);

    iva_pkg::t_state r_state;
    iva_pkg::t_state n_state;

    logic [3:0]      r_clock_level;
    logic [VW-1:0]   r_addr;
    logic [VW-1:0]   r_hi;
    logic [VW-1:0]   r_base;
    logic            r_op;
    logic            r_widen;
    logic            r_widened;
    iva_pkg::t_req   r_req;
    logic            r_rd_valid;
    logic [SLOT_W-1:0] r_rd_idx;
    logic            r_ok;
    logic            r_out_valid;
    logic            r_out_status;
    logic [7:0]      r_out_vec;
    logic [7:0]      r_out_users;

    logic              accept;
    logic              out_free;
    logic [VW-1:0]     in_base;
    logic [VW-1:0]     in_lo;
    logic [VW-1:0]     in_hi_raw;
    logic [VW-1:0]     in_hi;
    logic [VW-1:0]     wide_raw;
    logic [VW-1:0]     wide_hi;
    logic              can_widen;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;
    logic              sel_found;
    logic [SLOT_W-1:0] sel_idx;
    logic [COUNT_WIDTH-1:0] sel_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic [15:0]       users_ext;
    logic [15:0]       idx_ext;
    iva_pkg::t_marks   rd_marks;
    iva_pkg::t_marks   wr_marks;
    iva_pkg::t_req     in_req;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign out_free    = !r_out_valid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_base   = VW'(s_axis_tdata[3:0]) * SPL_V;
        if (s_axis_tuser == iva_pkg::OP_FIXED) begin
            in_lo     = VW'(s_axis_tdata[11:4]);
            in_hi_raw = VW'(s_axis_tdata[11:4]) + VW'(1);
        end else begin
            in_lo     = in_base;
            in_hi_raw = in_base + SPL_V;
        end
        in_hi     = (in_hi_raw > SLOTS_V) ? SLOTS_V : in_hi_raw;
        wide_raw  = VW'(r_clock_level) * SPL_V;
        wide_hi   = (wide_raw > SLOTS_V) ? SLOTS_V : wide_raw;
        can_widen = !r_widened && (r_op == iva_pkg::OP_LEVEL) && r_widen &&
                    (wide_hi > r_base);

        in_req.want_share = s_axis_tdata[12];
        in_req.want_move  = s_axis_tdata[13];
        in_req.check_move = (s_axis_tuser == iva_pkg::OP_LEVEL);
        in_req.polarity   = s_axis_tdata[16:15];
        in_req.trigger    = s_axis_tdata[18:17];

        new_count = sel_count + COUNT_WIDTH'(1);
        users_ext = 16'(new_count);
        idx_ext   = 16'(sel_idx);

        wr_marks.shareable = r_req.want_share;
        wr_marks.moveable  = r_req.want_move;
        wr_marks.polarity  = r_req.polarity;
        wr_marks.trigger   = r_req.trigger;

        rd_marks = ram_rdata[MARK_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iva_pkg::ST_CLEAR: begin
                if (r_addr == SLOTS_V - VW'(1)) begin
                    n_state = iva_pkg::ST_IDLE;
                end
            end
            iva_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (in_lo < in_hi) ? iva_pkg::ST_SCAN : iva_pkg::ST_DECIDE;
                end
            end
            iva_pkg::ST_SCAN: begin
                if (r_addr + VW'(1) == r_hi) begin
                    n_state = iva_pkg::ST_DRAIN;
                end
            end
            iva_pkg::ST_DRAIN: begin
                n_state = iva_pkg::ST_DECIDE;
            end
            iva_pkg::ST_DECIDE: begin
                if (!sel_found && can_widen) begin
                    n_state = iva_pkg::ST_SCAN;
                end else begin
                    n_state = iva_pkg::ST_DONE;
                end
            end
            iva_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = iva_pkg::ST_IDLE;
                end
            end
            default: n_state = iva_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_addr[SLOT_W-1:0];
        ram_wdata     = '0;
        unique case (r_state)
            iva_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
            end
            iva_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            iva_pkg::ST_DONE: begin
                ram_we    = out_free && r_ok;
                ram_waddr = sel_idx;
                ram_wdata = {new_count, wr_marks};
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= iva_pkg::ST_CLEAR;
            r_addr        <= '0;
            r_clock_level <= 4'd14;
            r_rd_valid    <= 1'b0;
            r_widened     <= 1'b0;
            r_ok          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= (r_state == iva_pkg::ST_SCAN);
            if (i_cfg_valid && o_cfg_ready) begin
                r_clock_level <= i_cfg_data;
            end
            unique case (r_state)
                iva_pkg::ST_CLEAR: begin
                    r_addr <= r_addr + VW'(1);
                end
                iva_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_addr    <= in_lo;
                        r_widened <= 1'b0;
                    end
                end
                iva_pkg::ST_SCAN: begin
                    r_addr <= r_addr + VW'(1);
                end
                iva_pkg::ST_DECIDE: begin
                    r_ok <= sel_found && (sel_count != COUNT_MAX);
                    if (!sel_found && can_widen) begin
                        r_addr    <= r_base;
                        r_widened <= 1'b1;
                    end
                end
                default: begin
                    r_ok <= r_ok;
                end
            endcase
            if (r_state == iva_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr[SLOT_W-1:0];
        if (accept) begin
            r_hi    <= in_hi;
            r_base  <= in_base;
            r_op    <= s_axis_tuser;
            r_widen <= s_axis_tdata[14];
            r_req   <= in_req;
        end
        if (r_state == iva_pkg::ST_DECIDE && !sel_found && can_widen) begin
            r_hi <= wide_hi;
        end
        if (r_state == iva_pkg::ST_DONE && out_free) begin
            if (r_ok) begin
                r_out_status <= iva_pkg::STATUS_OK;
                r_out_vec    <= idx_ext[7:0];
                r_out_users  <= users_ext[7:0];
            end else begin
                r_out_status <= iva_pkg::STATUS_FAIL;
                r_out_vec    <= '0;
                r_out_users  <= '0;
            end
        end
    end

    iva_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    iva_select #(
        .SLOT_W      (SLOT_W),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (accept),
        .i_valid (r_rd_valid),
        .i_idx   (r_rd_idx),
        .i_count (ram_rdata[DATA_W-1:MARK_W]),
        .i_marks (rd_marks),
        .i_req   (r_req),
        .o_found (sel_found),
        .o_idx   (sel_idx),
        .o_count (sel_count)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {r_out_users, r_out_vec};

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == iva_pkg::STATUS_FAIL) |-> m_axis_tdata == '0)
        else $error("failed allocation carries nonzero data");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == iva_pkg::ST_CLEAR) || (r_state == iva_pkg::ST_DONE))
        else $error("slot table written outside clear pass or completion");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == iva_pkg::ST_SCAN |-> (r_addr < r_hi) && (r_hi <= SLOTS_V))
        else $error("scan address outside its range");

    a_grant_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iva_pkg::ST_DONE) && r_ok |-> sel_found && (sel_count != COUNT_MAX))
        else $error("grant of a slot without a free count");

endmodule

// ===== tb/iva_grant_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iva_grant_checker
// Watches the request, result and configuration channels of the interrupt
// vector allocator. It keeps its own copy of the slot table and of the clock
// level, works out the grant for every accepted request, and compares every
// accepted result with the oldest grant still due.
// ----------------------------------------------------------------------------
module iva_grant_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [23:0] i_req_data,
    input  logic        i_req_op,
    input  logic        i_grant_valid,
    input  logic        i_grant_ready,
    input  logic [15:0] i_grant_data,
    input  logic        i_grant_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    output int          o_mismatches,
    output int          o_outstanding
);

    localparam int         NUM_SLOTS       = 256;
    localparam int         SLOTS_PER_LEVEL = 16;
    localparam logic [7:0] COUNT_MAX       = 8'hFF;
    localparam logic [3:0] CLOCK_LEVEL_RST = 4'd14;
    localparam int         REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [1:0] trigger;
        logic [1:0] polarity;
        logic       widen;
        logic       want_move;
        logic       want_share;
        logic [7:0] vector;
        logic [3:0] level;
    } t_alloc_req;

    typedef struct packed {
        logic       status;
        logic [7:0] users;
        logic [7:0] vector;
    } t_grant;

    logic [7:0]      slot_count [NUM_SLOTS];
    iva_pkg::t_marks slot_marks [NUM_SLOTS];
    logic [3:0]      clock_level;
    t_grant          grants_due [$];
    int              mismatches  = 0;
    int              outstanding = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;

    function automatic bit pins_fit(iva_pkg::t_marks m, t_alloc_req r);
        return (m.polarity == r.polarity || m.polarity == iva_pkg::PIN_ANY
                || r.polarity == iva_pkg::PIN_ANY)
            && (m.trigger == r.trigger || m.trigger == iva_pkg::PIN_ANY
                || r.trigger == iva_pkg::PIN_ANY);
    endfunction

    // Lowest count wins; a strict compare keeps the first slot on a tie.
    function automatic int best_slot(int lo, int hi, t_alloc_req r);
        int best;
        int v;
        best = -1;
        for (v = lo; v < hi && v < NUM_SLOTS; v++) begin
            if (slot_count[v] != 0 && !(slot_marks[v].shareable && r.want_share
                    && r.want_move == slot_marks[v].moveable
                    && pins_fit(slot_marks[v], r)))
                continue;
            if (best < 0 || slot_count[best] > slot_count[v])
                best = v;
        end
        return best;
    endfunction

    function automatic t_grant allocate(logic op, t_alloc_req r);
        int     pick;
        int     base;
        t_grant g;
        pick = -1;
        if (op == iva_pkg::OP_LEVEL) begin
            base = int'(r.level) * SLOTS_PER_LEVEL;
            pick = best_slot(base, base + SLOTS_PER_LEVEL, r);
            if (pick < 0 && r.widen)
                pick = best_slot(base, int'(clock_level) * SLOTS_PER_LEVEL, r);
        end else if (int'(r.vector) < NUM_SLOTS) begin
            pick = int'(r.vector);
            if (slot_count[pick] != 0 && !(r.want_share && slot_marks[pick].shareable
                    && pins_fit(slot_marks[pick], r)))
                pick = -1;
        end
        if (pick >= 0 && slot_count[pick] == COUNT_MAX)
            pick = -1;
        g = '0;
        g.status = iva_pkg::STATUS_FAIL;
        if (pick >= 0) begin
            slot_count[pick] = slot_count[pick] + 8'd1;
            slot_marks[pick] = '{r.want_share, r.want_move, r.polarity, r.trigger};
            g.status = iva_pkg::STATUS_OK;
            g.vector = pick[7:0];
            g.users  = slot_count[pick];
        end
        return g;
    endfunction

    task automatic report(string what, t_grant want, t_grant got);
        if (mismatches < REPORT_LIMIT)
            $display("%0t: %s: status %0d/%0d vector %0d/%0d users %0d/%0d (expected/actual)",
                     $time, what, want.status, got.status, want.vector, got.vector,
                     want.users, got.users);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_grant got;
        t_grant want;
        int     i;
        if (!i_rst_n) begin
            clock_level = CLOCK_LEVEL_RST;
            for (i = 0; i < NUM_SLOTS; i++) begin
                slot_count[i] = '0;
                slot_marks[i] = '0;
            end
            grants_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                clock_level = i_cfg_data;
            if (i_grant_valid && i_grant_ready) begin
                got = {i_grant_status, i_grant_data};
                if (grants_due.size() == 0) begin
                    report("result with no request pending", '0, got);
                end else begin
                    want = grants_due.pop_front();
                    if (got.status !== want.status || got.vector !== want.vector
                            || got.users !== want.users)
                        report("result mismatch", want, got);
                end
            end
            if (i_req_valid && i_req_ready)
                grants_due.push_back(allocate(i_req_op, t_alloc_req'(i_req_data[18:0])));
        end
        outstanding = grants_due.size();
    end

endmodule

// ===== tb/tb_irq_vector_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_irq_vector_allocator
// Drives requests and clock level writes into the interrupt vector allocator
// with random gaps and receiver stalls. A short directed run covers pin
// matching, sharing and the empty widened range; random phases under several
// clock levels fill levels, pile users onto single vectors and drive one
// vector to its maximum count. The checker predicts every result.
// ----------------------------------------------------------------------------
module tb_irq_vector_allocator;

    localparam int         HALF_PERIOD    = 10;
    localparam int         RESET_CYCLES   = 11;
    localparam int         STALL_LIMIT    = 4000;
    localparam int         RX_HOLD_CYCLES = 600;
    localparam int         SETTLE_CYCLES  = 300;
    localparam int         PHASE_ITEMS    = 375;
    localparam int         PILE_ITEMS     = 258;
    localparam logic [1:0] POL_HIGH       = 2'd1;
    localparam logic [1:0] POL_LOW        = 2'd2;
    localparam logic [1:0] TRIG_EDGE      = 2'd1;
    localparam logic [1:0] TRIG_LEVEL     = 2'd2;
    localparam logic [1:0] PIN_UNDEF      = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    int sent        = 0;
    bit calm        = 1'b0;
    bit rx_hold     = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    irq_vector_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    iva_grant_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (s_axis_tvalid),
        .i_req_ready    (s_axis_tready),
        .i_req_data     (s_axis_tdata),
        .i_req_op       (s_axis_tuser),
        .i_grant_valid  (m_axis_tvalid),
        .i_grant_ready  (m_axis_tready),
        .i_grant_data   (m_axis_tdata),
        .i_grant_status (m_axis_tuser),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL irq_vector_allocator");
                $finish;
            end
        end
    end

    // A change of rx_hold asks the receiver for one long hold.
    initial begin : receiver
        int stall;
        bit hold_seen;
        stall = 0;
        hold_seen = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold != hold_seen) begin
                hold_seen = rx_hold;
                m_axis_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready = 1'b0;
            end else begin
                stall = calm ? 0 : gap_len();
                m_axis_tready = (stall == 0);
                if (stall > 0)
                    stall--;
            end
        end
    end

    task automatic send_req(input logic op, input logic [3:0] lvl, input logic [7:0] vec,
                            input logic share, input logic move, input logic widen,
                            input logic [1:0] pol, input logic [1:0] trg);
        int gap;
        gap = calm ? 0 : gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tuser  = op;
        s_axis_tdata  = {5'b0, trg, pol, widen, move, share, vec, lvl};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_clock_level(input logic [3:0] lvl);
        @(negedge i_clk);
        i_cfg_data  = lvl;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_phase(input int items, input bit with_pile);
        int         first;
        int         kind;
        logic [3:0] lvl;
        logic [7:0] vec;
        logic       mv;
        logic       shr;
        logic [1:0] pol;
        logic [1:0] trg;
        first = sent;
        if (with_pile) begin
            repeat (40)
                send_req(1'($urandom_range(0, 1)), 4'($urandom), 8'($urandom),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                         2'($urandom_range(0, 3)));
            // The receiver stops while a long run on the top vector drives its
            // user count to the maximum and past it.
            rx_hold = ~rx_hold;
            repeat (PILE_ITEMS)
                send_req(iva_pkg::OP_FIXED, 4'($urandom), 8'hFF, 1'b1,
                         1'($urandom_range(0, 1)), 1'b0, iva_pkg::PIN_ANY,
                         iva_pkg::PIN_ANY);
        end
        while (sent - first < items) begin
            kind = $urandom_range(0, 99);
            lvl  = 4'($urandom_range(0, 15));
            vec  = 8'($urandom_range(0, 255));
            mv   = 1'($urandom_range(0, 1));
            shr  = ($urandom_range(0, 3) != 0);
            pol  = 2'($urandom_range(0, 2));
            trg  = 2'($urandom_range(0, 2));
            if (kind < 30) begin
                send_req(1'($urandom_range(0, 1)), lvl, vec, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            end else if (kind < 50) begin
                // Fill one level, then ask it for slots with the opposite move mark.
                repeat ($urandom_range(14, 18))
                    send_req(iva_pkg::OP_LEVEL, lvl, 8'($urandom), shr, mv, 1'b0, pol, trg);
                repeat ($urandom_range(1, 3))
                    send_req(iva_pkg::OP_LEVEL, lvl, 8'($urandom), 1'($urandom_range(0, 1)),
                             ~mv, ($urandom_range(0, 4) != 0), 2'($urandom_range(0, 2)),
                             2'($urandom_range(0, 2)));
            end else if (kind < 70) begin
                if ($urandom_range(0, 1))
                    pol = iva_pkg::PIN_ANY;
                repeat ($urandom_range(3, 12))
                    send_req(iva_pkg::OP_FIXED, 4'($urandom), vec,
                             ($urandom_range(0, 9) != 0), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), pol, trg);
            end else begin
                send_req(iva_pkg::OP_LEVEL, lvl, vec, ($urandom_range(0, 9) != 0), mv,
                         1'($urandom_range(0, 1)),
                         ($urandom_range(0, 1) ? iva_pkg::PIN_ANY : pol),
                         ($urandom_range(0, 1) ? iva_pkg::PIN_ANY : trg));
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = iva_pkg::OP_LEVEL;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_clock_level(4'd4);
        send_req(iva_pkg::OP_LEVEL, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0,
                 iva_pkg::PIN_ANY, iva_pkg::PIN_ANY);
        send_req(iva_pkg::OP_LEVEL, 4'd0, 8'hFF, 1'b1, 1'b1, 1'b0, POL_HIGH, TRIG_EDGE);
        send_req(iva_pkg::OP_LEVEL, 4'd0, 8'd0, 1'b1, 1'b1, 1'b0, POL_HIGH, TRIG_EDGE);
        send_req(iva_pkg::OP_LEVEL, 4'd15, 8'd0, 1'b1, 1'b0, 1'b1, POL_LOW, TRIG_LEVEL);
        send_req(iva_pkg::OP_FIXED, 4'd15, 8'hFF, 1'b1, 1'b1, 1'b0, PIN_UNDEF, PIN_UNDEF);
        send_req(iva_pkg::OP_FIXED, 4'd0, 8'hFF, 1'b1, 1'b0, 1'b1, PIN_UNDEF, PIN_UNDEF);
        send_req(iva_pkg::OP_FIXED, 4'd0, 8'hFF, 1'b1, 1'b0, 1'b0, POL_HIGH,
                 iva_pkg::PIN_ANY);
        send_req(iva_pkg::OP_FIXED, 4'd0, 8'hFF, 1'b1, 1'b0, 1'b0, iva_pkg::PIN_ANY,
                 TRIG_LEVEL);
        send_req(iva_pkg::OP_FIXED, 4'd0, 8'hFF, 1'b1, 1'b1, 1'b0,
                 iva_pkg::PIN_ANY, iva_pkg::PIN_ANY);
        send_req(iva_pkg::OP_FIXED, 4'd0, 8'h00, 1'b1, 1'b0, 1'b0,
                 iva_pkg::PIN_ANY, iva_pkg::PIN_ANY);
        send_req(iva_pkg::OP_FIXED, 4'd0, 8'h00, 1'b0, 1'b0, 1'b0,
                 iva_pkg::PIN_ANY, iva_pkg::PIN_ANY);
        send_req(iva_pkg::OP_FIXED, 4'd0, 8'h01, 1'b1, 1'b0, 1'b0, POL_HIGH, TRIG_EDGE);
        send_req(iva_pkg::OP_LEVEL, 4'd0, 8'd0, 1'b1, 1'b0, 1'b0, POL_HIGH, TRIG_EDGE);
        send_req(iva_pkg::OP_LEVEL, 4'd0, 8'd0, 1'b1, 1'b1, 1'b0, POL_LOW, TRIG_EDGE);
        send_req(iva_pkg::OP_FIXED, 4'd0, 8'h0F, 1'b0, 1'b0, 1'b0, POL_LOW, TRIG_LEVEL);
        send_req(iva_pkg::OP_FIXED, 4'd0, 8'h10, 1'b1, 1'b1, 1'b1, POL_LOW, TRIG_LEVEL);
        send_req(iva_pkg::OP_LEVEL, 4'd3, 8'd0, 1'b0, 1'b1, 1'b1, iva_pkg::PIN_ANY,
                 TRIG_EDGE);
        send_req(iva_pkg::OP_LEVEL, 4'd4, 8'd0, 1'b1, 1'b0, 1'b1, POL_HIGH,
                 iva_pkg::PIN_ANY);
        send_req(iva_pkg::OP_LEVEL, 4'd7, 8'h55, 1'b0, 1'b1, 1'b1, PIN_UNDEF, PIN_UNDEF);
        drain();

        set_clock_level(4'd15);
        run_phase(PHASE_ITEMS, 1'b1);
        calm = 1'b1;
        set_clock_level(4'd0);
        run_phase(PHASE_ITEMS, 1'b0);
        calm = 1'b0;
        set_clock_level(4'($urandom_range(1, 13)));
        run_phase(PHASE_ITEMS, 1'b0);
        set_clock_level(4'd8);
        run_phase(PHASE_ITEMS, 1'b0);
        set_clock_level(4'd14);
        run_phase(PHASE_ITEMS, 1'b0);

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS irq_vector_allocator");
        else
            $display("FAIL irq_vector_allocator");
        $finish;
    end

endmodule

// ===== irq_vector_allocator.f =====
design/iva_pkg.sv
design/iva_ram.sv
design/iva_select.sv
design/irq_vector_allocator.sv
tb/iva_grant_checker.sv
tb/tb_irq_vector_allocator.sv
